@@ sv/tcslf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcslf_pkg
// Shared types and byte codes for the telnet command strip line framer.
// ----------------------------------------------------------------------------
package tcslf_pkg;

	// Telnet and line control byte codes
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_IP   = 8'hF4;
	localparam logic [7:0] CH_WILL = 8'hFB;
	localparam logic [7:0] CH_WONT = 8'hFC;
	localparam logic [7:0] CH_DO   = 8'hFD;
	localparam logic [7:0] CH_DONT = 8'hFE;
	localparam logic [7:0] CH_IAC  = 8'hFF;

	// Result queue geometry
	localparam int unsigned QDepth = 4;
	localparam int unsigned PtrW   = $clog2(QDepth);
	localparam int unsigned CntW   = $clog2(QDepth + 1);

	// Parser phase
	typedef enum logic [2:0] {
		PH_TEXT   = 3'd0,
		PH_IAC    = 3'd1,
		PH_OPT    = 3'd2,
		PH_EOL_CR = 3'd3,
		PH_EOL_LF = 3'd4
	} phase_t;

	// Result kind
	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_LINE    = 2'd1,
		KIND_DISCARD = 2'd2,
		KIND_DISC    = 2'd3
	} kind_t;

	// One result entry
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} result_t;

endpackage

@@ sv/telnet_command_strip_line_framer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_command_strip_line_framer
// Splits a received telnet byte stream into lines and strips telnet commands.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Payload
//  -------   ---------  ------------------  ----------------------------------
//  input     in         in_valid/in_stall   rx_byte[7:0]
//  output    out        out_valid/out_stall out_kind[1:0] out_byte[7:0]
//                                           last_of_item
//
//  A byte is registered on acceptance and decoded from that register, which
//  writes zero, one or two transactions into a four-entry result queue once
//  the queue has room. A byte is taken every cycle while the queue has room;
//  the output port drains one transaction per cycle while out_stall is low,
//  so bytes that cause two results limit the byte rate under sustained load.
//  Reset returns the parser to plain text and empties the queue.
//  in_stall rises only while the registered byte waits for queue room.
// ----------------------------------------------------------------------------
module telnet_command_strip_line_framer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] out_kind,
	output logic [7:0] out_byte,
	output logic       last_of_item
);
	import tcslf_pkg::*;

	logic            valid_s1;
	logic [7:0]      byte_s1;
	phase_t          phase_q;
	phase_t          phase_d;
	result_t         res0;
	result_t         res1;
	logic [1:0]      n_res;
	result_t         queue_q [QDepth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;
	logic            pop;
	logic            room;
	logic            proc;
	logic            accept;
	result_t         head;

	// Handshake decisions
	assign pop      = out_valid && !out_stall;
	assign room     = (cnt_q <= CntW'(QDepth - 2)) ||
	                  ((cnt_q == CntW'(QDepth - 1)) && pop);
	assign proc     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept   = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

	// Phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TEXT;
		end else if (proc) begin
			phase_q <= phase_d;
		end
	end

	// Decode one byte against the current phase
	always_comb begin
		n_res   = 2'd0;
		res0    = '{kind: KIND_BYTE, data: byte_s1, last: 1'b0};
		res1    = '{kind: KIND_BYTE, data: byte_s1, last: 1'b0};
		phase_d = phase_q;
		unique case (phase_q)
			PH_IAC: begin
				if (byte_s1 inside {CH_WILL, CH_WONT, CH_DO, CH_DONT}) begin
					phase_d = PH_OPT;
				end else if (byte_s1 == CH_IP) begin
					phase_d = PH_TEXT;
					n_res   = 2'd1;
					res0    = '{kind: KIND_DISC, data: 8'h00, last: 1'b0};
				end else begin
					phase_d = PH_TEXT;
					n_res   = 2'd1;
					res0    = '{kind: KIND_DISCARD, data: 8'h00, last: 1'b0};
				end
			end
			PH_OPT: begin
				phase_d = PH_TEXT;
				n_res   = 2'd1;
				res0    = '{kind: KIND_DISCARD, data: 8'h00, last: 1'b0};
			end
			PH_EOL_CR, PH_EOL_LF: begin
				if (byte_s1 == CH_NUL) begin
					// hold the run open
				end else if (byte_s1 == CH_CR) begin
					n_res = 2'd1;
				end else if (byte_s1 == CH_LF && phase_q == PH_EOL_CR) begin
					phase_d = PH_EOL_LF;
					n_res   = 2'd1;
				end else begin
					// close the line, then treat the byte as plain text
					res0 = '{kind: KIND_LINE, data: 8'h00, last: 1'b0};
					if (byte_s1 == CH_IAC) begin
						phase_d = PH_IAC;
						n_res   = 2'd1;
					end else begin
						phase_d = (byte_s1 == CH_LF) ? PH_EOL_LF : PH_TEXT;
						n_res   = 2'd2;
					end
				end
			end
			default: begin
				if (byte_s1 == CH_NUL) begin
					phase_d = PH_TEXT;
				end else if (byte_s1 == CH_IAC) begin
					phase_d = PH_IAC;
				end else begin
					n_res = 2'd1;
					if (byte_s1 == CH_CR) begin
						phase_d = PH_EOL_CR;
					end else if (byte_s1 == CH_LF) begin
						phase_d = PH_EOL_LF;
					end else begin
						phase_d = PH_TEXT;
					end
				end
			end
		endcase
		// Mark the final result of the byte
		if (n_res == 2'd1) begin
			res0.last = 1'b1;
		end
		if (n_res == 2'd2) begin
			res1.last = 1'b1;
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (proc && n_res != 2'd0) begin
			queue_q[wr_q] <= res0;
		end
		if (proc && n_res == 2'd2) begin
			queue_q[wr_q + PtrW'(1)] <= res1;
		end
	end

	// Result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (proc) begin
				wr_q <= wr_q + PtrW'(n_res);
			end
			if (pop) begin
				rd_q <= rd_q + PtrW'(1);
			end
			cnt_q <= cnt_q + (proc ? CntW'(n_res) : CntW'(0)) - CntW'(pop);
		end
	end

	// Drive the output transaction from the queue head
	assign head         = queue_q[rd_q];
	assign out_valid    = (cnt_q != '0);
	assign out_kind     = head.kind;
	assign out_byte     = head.data;
	assign last_of_item = head.last;

endmodule

@@ test/telnet_command_strip_line_framer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_command_strip_line_framer_tb
// Drives received telnet bytes into the framer and checks every result
// transaction against a cycle-free model of the parse phase machine. A short
// directed sequence covers commands, end-of-line runs and NUL handling, then
// random well-formed lines and commands mixed with noise follow, under
// changing sender and receiver idle rates, a long receiver hold-off and
// sender pauses that wait for the result stream to drain.
// ----------------------------------------------------------------------------
module telnet_command_strip_line_framer_tb;
	import tcslf_pkg::*;

	localparam int RANDOM_BYTES = 1650;
	localparam int HOLD_CYCLES  = 250;

	typedef struct {
		logic [7:0] value;
		bit         drain;
	} tx_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic       last_of_item;

	tx_byte_t byte_backlog[$];
	result_t  due_results[$];
	result_t  byte_results[$];
	phase_t   model_phase = PH_TEXT;
	tx_byte_t next_tx;
	result_t  want;
	int       sent_cnt = 0;
	int       total_bytes = 0;
	int       err_cnt = 0;
	int       hold_left = 0;
	bit       hold_done = 1'b0;
	bit       drain_armed = 1'b0;

	telnet_command_strip_line_framer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_kind     (out_kind),
		.out_byte     (out_byte),
		.last_of_item (last_of_item)
	);

	// Clock and reset
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Idle percentage for each side, by run phase
	function automatic int idle_pct(input bit sender);
		if (sent_cnt < total_bytes / 3)
			return sender ? 13 : 81;
		if (sent_cnt < 2 * total_bytes / 3)
			return sender ? 81 : 13;
		return 0;
	endfunction

	function automatic result_t framer_result(input kind_t k, input logic [7:0] b);
		result_t r;
		r.kind = k;
		r.data = (k == KIND_BYTE) ? b : 8'h00;
		r.last = 1'b0;
		return r;
	endfunction

	// Handle a non-NUL byte as plain text
	task frame_text(input logic [7:0] b);
		if (b == CH_IAC) begin
			model_phase = PH_IAC;
		end else begin
			if (b == CH_CR)
				model_phase = PH_EOL_CR;
			else if (b == CH_LF)
				model_phase = PH_EOL_LF;
			else
				model_phase = PH_TEXT;
			byte_results.push_back(framer_result(KIND_BYTE, b));
		end
	endtask

	// Advance the phase machine by one byte and queue the results it causes
	task frame_byte(input logic [7:0] b);
		byte_results.delete();
		case (model_phase)
			PH_IAC: begin
				if (b == CH_WILL || b == CH_WONT || b == CH_DO || b == CH_DONT) begin
					model_phase = PH_OPT;
				end else begin
					model_phase = PH_TEXT;
					byte_results.push_back(framer_result((b == CH_IP) ? KIND_DISC : KIND_DISCARD,
						8'h00));
				end
			end
			PH_OPT: begin
				model_phase = PH_TEXT;
				byte_results.push_back(framer_result(KIND_DISCARD, 8'h00));
			end
			PH_EOL_CR, PH_EOL_LF: begin
				if (b == CH_CR || (b == CH_LF && model_phase == PH_EOL_CR)) begin
					if (b == CH_LF)
						model_phase = PH_EOL_LF;
					byte_results.push_back(framer_result(KIND_BYTE, b));
				end else if (b != CH_NUL) begin
					byte_results.push_back(framer_result(KIND_LINE, 8'h00));
					frame_text(b);
				end
			end
			default: begin
				// NUL in text is dropped
				if (b != CH_NUL)
					frame_text(b);
			end
		endcase
		if (byte_results.size() != 0)
			byte_results[byte_results.size() - 1].last = 1'b1;
		foreach (byte_results[i])
			due_results.push_back(byte_results[i]);
	endtask

	task add_byte(input logic [7:0] b);
		tx_byte_t t;
		t.value = b;
		t.drain = drain_armed;
		drain_armed = 1'b0;
		byte_backlog.push_back(t);
	endtask

	// Sender: offer bytes from the backlog, hold while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte  <= 8'h00;
		end else begin
			if (in_valid && !in_stall) begin
				frame_byte(rx_byte);
				sent_cnt++;
			end
			if (!in_valid || !in_stall) begin
				if (byte_backlog.size() != 0
						&& !(byte_backlog[0].drain && due_results.size() != 0)
						&& $urandom_range(99) >= idle_pct(1'b1)) begin
					next_tx = byte_backlog.pop_front();
					in_valid <= 1'b1;
					rx_byte  <= next_tx.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls plus one long hold-off late in the run
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!hold_done && sent_cnt >= total_bytes * 5 / 6) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < idle_pct(1'b0));
		end
	end

	// Check each result transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result: kind %0d byte %h last %b",
					$time, out_kind, out_byte, last_of_item);
				err_cnt++;
			end else begin
				want = due_results.pop_front();
				if ({out_kind, out_byte, last_of_item} !== want) begin
					$display("%0t: expected kind %0d byte %h last %b, got kind %0d byte %h last %b",
						$time, want.kind, want.data, want.last, out_kind, out_byte, last_of_item);
					err_cnt++;
				end
			end
		end
	end

	// Stimulus and end of run
	initial begin
		logic [7:0] directed[] = '{
			8'h42, CH_NUL, CH_CR, CH_NUL, CH_LF, CH_CR, 8'h41, CH_LF, CH_LF, 8'h80,
			CH_IAC, CH_WILL, CH_NUL, CH_IAC, CH_WONT, 8'h7F, CH_IAC, CH_DO, CH_IAC,
			CH_IAC, CH_DONT, 8'h01, CH_IAC, CH_IP, CH_IAC, CH_IAC, CH_CR, CH_IAC, CH_NUL
		};
		int next_mark;
		int n;
		logic [7:0] c;

		foreach (directed[i])
			add_byte(directed[i]);
		next_mark = 450;
		while (byte_backlog.size() < directed.size() + RANDOM_BYTES) begin
			// Make the sender wait for the result stream to drain now and then
			if (byte_backlog.size() >= next_mark) begin
				drain_armed = 1'b1;
				next_mark += 450;
			end
			n = $urandom_range(99);
			if (n < 45) begin
				// Text line closed by an end-of-line run
				repeat ($urandom_range(1, 12)) begin
					c = 8'($urandom_range(1, 254));
					if (c == CH_CR || c == CH_LF)
						c = 8'h2E;
					add_byte(c);
					if ($urandom_range(15) == 0)
						add_byte(CH_NUL);
				end
				case ($urandom_range(4))
					0: begin add_byte(CH_CR); add_byte(CH_LF); end
					1: add_byte(CH_LF);
					2: add_byte(CH_CR);
					3: begin add_byte(CH_CR); add_byte(CH_CR); add_byte(CH_LF); end
					default: begin add_byte(CH_LF); add_byte(CH_CR); add_byte(CH_CR); end
				endcase
			end else if (n < 65) begin
				// Option negotiation
				add_byte(CH_IAC);
				add_byte(8'($urandom_range(CH_WILL, CH_DONT)));
				add_byte(8'($urandom_range(255)));
			end else if (n < 75) begin
				add_byte(CH_IAC);
				add_byte(8'($urandom_range(255)));
			end else if (n < 80) begin
				add_byte(CH_IAC);
				add_byte(CH_IP);
			end else if (n < 90) begin
				repeat ($urandom_range(1, 4))
					add_byte(8'($urandom_range(255)));
			end else begin
				// Broken sequences
				add_byte(CH_LF);
				add_byte($urandom_range(1) ? CH_LF : CH_IAC);
			end
		end
		total_bytes = byte_backlog.size();

		// Wait for the backlog to go out and the results to come back
		@(posedge clk);
		while (byte_backlog.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (err_cnt == 0)
			$display("telnet_command_strip_line_framer_tb: done, clean");
		else
			$display("telnet_command_strip_line_framer_tb: done, errors");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("telnet_command_strip_line_framer_tb: done, errors");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/tcslf_pkg.sv
sv/telnet_command_strip_line_framer.sv
test/telnet_command_strip_line_framer_tb.sv
